// ===== hw/rtl/aavr_pkg.sv =====
package aavr_pkg;

    // component and fixed-point widths
    localparam int COMP_W = 32;
    localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
    localparam logic signed [65:0] Q30_HALF = 66'sd536870912;

    // mode codes
    localparam logic [1:0] MODE_X    = 2'd0;
    localparam logic [1:0] MODE_Y    = 2'd1;
    localparam logic [1:0] MODE_Z    = 2'd2;
    localparam logic [1:0] MODE_AXIS = 2'd3;

    // cordic
    localparam int CORDIC_STEPS = 28;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

    // stage map
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 31;
    localparam int ST_CORDIC0    = 1;
    localparam int ST_QUAD       = ST_CORDIC0 + CORDIC_STEPS;
    localparam int ST_LZC        = 1;
    localparam int ST_SHIFT      = 2;
    localparam int ST_SQUARE     = 3;
    localparam int ST_SUM        = 4;
    localparam int ST_SQRT0      = 5;
    localparam int ST_NUM        = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0       = ST_NUM + 1;
    localparam int ST_FRONT_LAST = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_UNIT       = ST_FRONT_LAST + 1;
    localparam int ST_AXPROD     = ST_UNIT + 1;
    localparam int ST_DPROD      = ST_AXPROD + 1;
    localparam int ST_MATRIX     = ST_DPROD + 1;
    localparam int ST_VPROD      = ST_MATRIX + 1;
    localparam int ST_OUT        = ST_VPROD + 1;

    // front pipeline: axis normalisation and sine/cosine side by side
    typedef struct packed {
        logic [1:0]         mode;
        logic               zero;
        logic [2:0]         neg;
        logic [31:0]        vx;
        logic [31:0]        vy;
        logic [31:0]        vz;
        logic [31:0]        mmax;
        logic [4:0]         sh;
        logic [2:0][31:0]   mag;
        logic [2:0][63:0]   sq;
        logic [63:0]        rem;
        logic [63:0]        root;
        logic [2:0][62:0]   num;
        logic [2:0][30:0]   quo;
        logic [1:0]         quad;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] cz;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_front;

    // vector and flag riding alongside the matrix stages
    typedef struct packed {
        logic [2:0][31:0] vec;
        logic             zero;
    } t_side;

endpackage

// ===== hw/rtl/axis_angle_vector_rotation_core.sv =====
// Axis-angle rotation of a Q15.16 vector (Rodrigues form).
// Input channel: i_valid / o_stall with the mode, vector, axis and binary
// angle fields; an item is taken at an edge where i_valid is high and o_stall
// is low. Output channel: o_valid / i_stall with the rotated vector and the
// zero-axis flag; an item leaves at an edge where o_valid is high and i_stall
// is low.
// Throughput: one item per cycle while the receiver does not stall. The
// depth is set by the bit-per-stage square root (32 stages) and the
// bit-per-stage axis divide (31 stages), with the 28-step cordic running
// beside them.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_stall rises; nothing is dropped or repeated. Empty stages are
// still filled while the output is free.
// Reset (synchronous, active low) clears every stage valid bit; data
// registers are not reset. The block keeps no state between items.
module axis_angle_vector_rotation_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_vec_x,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_vec_y,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_vec_z,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_axis_x,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_axis_y,
    input  logic signed [aavr_pkg::COMP_W-1:0]  i_axis_z,
    input  logic signed [31:0]                  i_turn_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aavr_pkg::COMP_W-1:0]  o_out_x,
    output logic signed [aavr_pkg::COMP_W-1:0]  o_out_y,
    output logic signed [aavr_pkg::COMP_W-1:0]  o_out_z,
    output logic                                o_axis_was_zero
);
    import aavr_pkg::*;

    // clamp to [-1, 1] in q2.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
        logic signed [31:0] res;
        begin
            if (v > Q30_ONE) begin
                res = 32'(Q30_ONE);
            end else if (v < -Q30_ONE) begin
                res = 32'(-Q30_ONE);
            end else begin
                res = 32'(v);
            end
            return res;
        end
    endfunction

    // rounded q2.30 product
    function automatic logic signed [33:0] mulq(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        begin
            p = a * b;
            p = p + Q30_HALF;
            return 34'(p >>> 30);
        end
    endfunction

    // one stage of the front pipeline, k picks the work of that stage
    function automatic t_front front_step(input int k, input t_front p);
        t_front             n;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        logic signed [33:0] c34;
        logic signed [33:0] s34;
        logic [63:0]        b;
        logic [63:0]        trial;
        logic [62:0]        dsub;
        int                 i;
        begin
            n = p;
            // cordic micro-rotation
            if (k >= ST_CORDIC0 && k < ST_QUAD) begin
                i  = k - ST_CORDIC0;
                dx = $signed(p.cy) >>> i;
                dy = $signed(p.cx) >>> i;
                at = $signed({2'b00, ATAN_TAB[i]});
                if (!p.cz[33]) begin
                    n.cx = p.cx - dx;
                    n.cy = p.cy + dy;
                    n.cz = p.cz - at;
                end else begin
                    n.cx = p.cx + dx;
                    n.cy = p.cy - dy;
                    n.cz = p.cz + at;
                end
            end
            // quadrant fold-back
            if (k == ST_QUAD) begin
                case (p.quad)
                    2'd0: begin
                        c34 = p.cx;
                        s34 = p.cy;
                    end
                    2'd1: begin
                        c34 = -p.cy;
                        s34 = p.cx;
                    end
                    2'd2: begin
                        c34 = -p.cx;
                        s34 = -p.cy;
                    end
                    default: begin
                        c34 = p.cy;
                        s34 = -p.cx;
                    end
                endcase
                n.cos_v = clamp_q30(36'(c34));
                n.sin_v = clamp_q30(36'(s34));
            end
            // normalising shift count
            if (k == ST_LZC) begin
                n.sh = 5'd0;
                for (int j = 0; j < 31; j++) begin
                    if (p.mmax[j]) begin
                        n.sh = 5'(30 - j);
                    end
                end
                if (p.mmax[31]) begin
                    n.sh = 5'd0;
                end
            end
            if (k == ST_SHIFT) begin
                for (int j = 0; j < 3; j++) begin
                    n.mag[j] = p.mag[j] << p.sh;
                end
            end
            if (k == ST_SQUARE) begin
                for (int j = 0; j < 3; j++) begin
                    n.sq[j] = 64'(p.mag[j]) * 64'(p.mag[j]);
                end
            end
            if (k == ST_SUM) begin
                n.rem  = p.sq[0] + p.sq[1] + p.sq[2];
                n.root = 64'd0;
            end
            // square root, one result bit per stage
            if (k >= ST_SQRT0 && k < ST_NUM) begin
                i     = k - ST_SQRT0;
                b     = 64'd1 << (62 - 2 * i);
                trial = p.root + b;
                if (p.rem >= trial) begin
                    n.rem  = p.rem - trial;
                    n.root = (p.root >> 1) + b;
                end else begin
                    n.root = p.root >> 1;
                end
            end
            // rounded dividends
            if (k == ST_NUM) begin
                for (int j = 0; j < 3; j++) begin
                    n.num[j] = 63'({p.mag[j], 30'd0}) + 63'(p.root >> 1);
                end
                n.quo = '0;
            end
            // restoring divide, one quotient bit per stage
            if (k >= ST_DIV0 && k <= ST_FRONT_LAST) begin
                i    = 30 - (k - ST_DIV0);
                dsub = 63'(p.root[31:0]) << i;
                for (int j = 0; j < 3; j++) begin
                    if (p.num[j] >= dsub) begin
                        n.num[j]    = p.num[j] - dsub;
                        n.quo[j][i] = 1'b1;
                    end
                end
            end
            return n;
        end
    endfunction

    logic                  w_en;
    logic [ST_OUT:0]       r_vld;
    t_front                n_front0;
    t_front                r_front [0:ST_FRONT_LAST];
    t_side                 r_side [ST_UNIT:ST_VPROD];
    logic [31:0]           w_tq;
    logic [31:0]           w_res;

    logic signed [31:0]    n_u [3];
    logic signed [31:0]    r_u [3];
    logic signed [31:0]    r_c1;
    logic signed [31:0]    r_s1;
    logic signed [32:0]    r_d1;
    logic signed [33:0]    n_uu [6];
    logic signed [33:0]    r_uu [6];
    logic signed [33:0]    n_su [3];
    logic signed [33:0]    r_su2 [3];
    logic signed [31:0]    r_c2;
    logic signed [32:0]    r_d2;
    logic signed [33:0]    n_duu [6];
    logic signed [33:0]    r_duu [6];
    logic signed [33:0]    r_su3 [3];
    logic signed [31:0]    r_c3;
    logic signed [31:0]    n_mat [9];
    logic signed [31:0]    r_mat [9];
    logic signed [63:0]    n_prod [9];
    logic signed [63:0]    r_prod [9];
    logic signed [31:0]    n_out [3];
    logic signed [31:0]    r_out [3];
    logic                  r_zero_out;

    // global advance: hold everything while a result waits on a stalled output
    assign w_en    = !(r_vld[ST_OUT] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[ST_OUT];

    // input stage: magnitudes, largest magnitude, quadrant split
    assign w_tq  = i_turn_angle + 32'h2000_0000;
    assign w_res = i_turn_angle - {w_tq[31:30], 30'd0};

    always_comb begin
        n_front0        = '0;
        n_front0.mode   = i_mode;
        n_front0.vx     = i_vec_x;
        n_front0.vy     = i_vec_y;
        n_front0.vz     = i_vec_z;
        n_front0.neg    = {i_axis_z[31], i_axis_y[31], i_axis_x[31]};
        n_front0.mag[0] = i_axis_x[31] ? (~i_axis_x + 32'd1) : i_axis_x;
        n_front0.mag[1] = i_axis_y[31] ? (~i_axis_y + 32'd1) : i_axis_y;
        n_front0.mag[2] = i_axis_z[31] ? (~i_axis_z + 32'd1) : i_axis_z;
        n_front0.mmax   = n_front0.mag[0];
        if (n_front0.mag[1] > n_front0.mmax) begin
            n_front0.mmax = n_front0.mag[1];
        end
        if (n_front0.mag[2] > n_front0.mmax) begin
            n_front0.mmax = n_front0.mag[2];
        end
        n_front0.zero = (i_mode == MODE_AXIS) && (n_front0.mmax == 32'd0);
        n_front0.quad = w_tq[31:30];
        n_front0.cx   = CORDIC_GAIN;
        n_front0.cy   = 34'sd0;
        n_front0.cz   = 34'($signed(w_res));
    end

    // unit axis: fixed axes, zero axis, or signed clamped quotient
    always_comb begin
        logic [30:0] qv;
        for (int j = 0; j < 3; j++) begin
            qv = r_front[ST_FRONT_LAST].quo[j];
            if (qv > 31'd1073741824) begin
                qv = 31'd1073741824;
            end
            if (r_front[ST_FRONT_LAST].mode == MODE_AXIS) begin
                if (r_front[ST_FRONT_LAST].zero) begin
                    n_u[j] = 32'sd0;
                end else if (r_front[ST_FRONT_LAST].neg[j]) begin
                    n_u[j] = -$signed({1'b0, qv});
                end else begin
                    n_u[j] = $signed({1'b0, qv});
                end
            end else begin
                n_u[j] = (r_front[ST_FRONT_LAST].mode == 2'(j)) ? 32'(Q30_ONE) : 32'sd0;
            end
        end
    end

    // axis products and sine terms
    always_comb begin
        n_uu[0] = mulq(33'(r_u[0]), 33'(r_u[0]));
        n_uu[1] = mulq(33'(r_u[1]), 33'(r_u[1]));
        n_uu[2] = mulq(33'(r_u[2]), 33'(r_u[2]));
        n_uu[3] = mulq(33'(r_u[0]), 33'(r_u[1]));
        n_uu[4] = mulq(33'(r_u[0]), 33'(r_u[2]));
        n_uu[5] = mulq(33'(r_u[1]), 33'(r_u[2]));
        for (int j = 0; j < 3; j++) begin
            n_su[j] = mulq(33'(r_s1), 33'(r_u[j]));
        end
    end

    // scale by one minus cosine
    always_comb begin
        for (int m = 0; m < 6; m++) begin
            n_duu[m] = mulq(r_d2, 33'(r_uu[m]));
        end
    end

    // rotation matrix entries
    always_comb begin
        n_mat[0] = clamp_q30(36'(r_c3) + 36'(r_duu[0]));
        n_mat[4] = clamp_q30(36'(r_c3) + 36'(r_duu[1]));
        n_mat[8] = clamp_q30(36'(r_c3) + 36'(r_duu[2]));
        n_mat[1] = clamp_q30(36'(r_duu[3]) - 36'(r_su3[2]));
        n_mat[3] = clamp_q30(36'(r_duu[3]) + 36'(r_su3[2]));
        n_mat[2] = clamp_q30(36'(r_duu[4]) + 36'(r_su3[1]));
        n_mat[6] = clamp_q30(36'(r_duu[4]) - 36'(r_su3[1]));
        n_mat[5] = clamp_q30(36'(r_duu[5]) - 36'(r_su3[0]));
        n_mat[7] = clamp_q30(36'(r_duu[5]) + 36'(r_su3[0]));
    end

    // matrix times vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i * 3 + j] = r_mat[i * 3 + j] * $signed(r_side[ST_MATRIX].vec[j]);
            end
        end
    end

    // row sums, rounding and saturation
    always_comb begin
        logic signed [65:0] acc;
        logic signed [65:0] t;
        for (int i = 0; i < 3; i++) begin
            acc = 66'(r_prod[i * 3]) + 66'(r_prod[i * 3 + 1]) + 66'(r_prod[i * 3 + 2])
                + Q30_HALF;
            t = acc >>> 30;
            if (t > 66'sd2147483647) begin
                n_out[i] = 32'sh7fff_ffff;
            end else if (t < -66'sd2147483648) begin
                n_out[i] = 32'sh8000_0000;
            end else begin
                n_out[i] = 32'(t);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-1:0], i_valid};
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front[0] <= n_front0;
            for (int k = 1; k <= ST_FRONT_LAST; k++) begin
                r_front[k] <= front_step(k, r_front[k - 1]);
            end
            r_side[ST_UNIT] <= {r_front[ST_FRONT_LAST].vz, r_front[ST_FRONT_LAST].vy,
                                r_front[ST_FRONT_LAST].vx, r_front[ST_FRONT_LAST].zero};
            for (int k = ST_UNIT + 1; k <= ST_VPROD; k++) begin
                r_side[k] <= r_side[k - 1];
            end
            r_u   <= n_u;
            r_c1  <= r_front[ST_FRONT_LAST].cos_v;
            r_s1  <= r_front[ST_FRONT_LAST].sin_v;
            r_d1  <= 33'(Q30_ONE) - 33'(r_front[ST_FRONT_LAST].cos_v);
            r_uu  <= n_uu;
            r_su2 <= n_su;
            r_c2  <= r_c1;
            r_d2  <= r_d1;
            r_duu <= n_duu;
            r_su3 <= r_su2;
            r_c3  <= r_c2;
            r_mat <= n_mat;
            r_prod <= n_prod;
            r_out <= n_out;
            r_zero_out <= r_side[ST_VPROD].zero;
        end
    end

    assign o_out_x         = r_out[0];
    assign o_out_y         = r_out[1];
    assign o_out_z         = r_out[2];
    assign o_axis_was_zero = r_zero_out;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import aavr_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  N_RANDOM     = 450;
    localparam int  DRAIN_CYCLES = 120;

    // one item as it enters the block
    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] vec [3];
        logic signed [31:0] axis [3];
        logic signed [31:0] angle;
    } t_rot_req;

    // one rotated vector as it leaves the block
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
    } t_rot_res;

    // scoreboard: predicts each rotation and matches results in order
    class t_rotation_board;
        t_rot_res    pending_vecs [$];
        int          n_errors;
        longint      atan_q32 [28];

        function new();
            atan_q32 = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                163, 81, 41, 20, 10, 5};
            n_errors = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // rounded product of two q2.30 values
        function longint q30_mul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // cordic sine and cosine with quadrant folding
        function void angle_sin_cos(logic [31:0] ang, output longint c, output longint s);
            logic [31:0] shifted, resid;
            logic [1:0]  quad;
            longint      x, y, z, nx;
            shifted = ang + 32'h2000_0000;
            quad = shifted[31:30];
            resid = ang - {quad, 30'd0};
            z = longint'(signed'(resid));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 28; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_q32[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_q32[i];
                end
                x = nx;
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            c = clip(c, -(64'sd1 <<< 30), 64'sd1 <<< 30);
            s = clip(s, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        endfunction

        // unit axis in q2.30; returns 1 for a zero-length axis
        function bit unit_axis(logic signed [31:0] a [3], output longint u [3]);
            longint unsigned mag [3];
            longint unsigned m, total, len, quo;
            longint          lim;
            m = 0;
            total = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = a[i] < 0 ? longint'(-longint'(a[i])) : longint'(a[i]);
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                u = '{0, 0, 0};
                return 1;
            end
            while (m < (64'd1 << 30)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            for (int i = 0; i < 3; i++) total = total + mag[i] * mag[i];
            len = int_sqrt(total);
            for (int i = 0; i < 3; i++) begin
                quo = ((mag[i] << 30) + (len >> 1)) / len;
                lim = quo > (64'd1 << 30) ? (64'sd1 <<< 30) : longint'(quo);
                u[i] = a[i] < 0 ? -lim : lim;
            end
            return 0;
        endfunction

        function t_rot_res rotate_vector(t_rot_req rq);
            longint   u [3];
            longint   m [3][3];
            longint   c, s, d, acc, one;
            longint   comp [3];
            bit       zero;
            t_rot_res res;
            one = 64'sd1 <<< 30;
            zero = 0;
            if (rq.mode == MODE_AXIS) begin
                zero = unit_axis(rq.axis, u);
            end else begin
                u = '{0, 0, 0};
                u[rq.mode] = one;
            end
            angle_sin_cos(rq.angle, c, s);
            d = one - c;
            m[0][0] = c + q30_mul(d, q30_mul(u[0], u[0]));
            m[1][1] = c + q30_mul(d, q30_mul(u[1], u[1]));
            m[2][2] = c + q30_mul(d, q30_mul(u[2], u[2]));
            m[0][1] = q30_mul(d, q30_mul(u[0], u[1])) - q30_mul(s, u[2]);
            m[1][0] = q30_mul(d, q30_mul(u[0], u[1])) + q30_mul(s, u[2]);
            m[0][2] = q30_mul(d, q30_mul(u[0], u[2])) + q30_mul(s, u[1]);
            m[2][0] = q30_mul(d, q30_mul(u[0], u[2])) - q30_mul(s, u[1]);
            m[1][2] = q30_mul(d, q30_mul(u[1], u[2])) - q30_mul(s, u[0]);
            m[2][1] = q30_mul(d, q30_mul(u[1], u[2])) + q30_mul(s, u[0]);
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc = acc + clip(m[i][j], -one, one) * longint'(rq.vec[j]);
                comp[i] = clip((acc + (one >>> 1)) >>> 30,
                               -64'sd2147483648, 64'sd2147483647);
            end
            res.x = comp[0][31:0];
            res.y = comp[1][31:0];
            res.z = comp[2][31:0];
            res.zero = zero;
            return res;
        endfunction

        function void note_input(t_rot_req rq);
            pending_vecs.push_back(rotate_vector(rq));
        endfunction

        function void check_result(t_rot_res got);
            t_rot_res want;
            if (pending_vecs.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d zero=%0b",
                         $time, got.x, got.y, got.z, got.zero);
                n_errors++;
                return;
            end
            want = pending_vecs.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
                n_errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
                n_errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: out_z expected %0d actual %0d", $time, want.z, got.z);
                n_errors++;
            end
            if (got.zero !== want.zero) begin
                $display("%0t: axis_was_zero expected %0b actual %0b",
                         $time, want.zero, got.zero);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic signed [31:0] i_vec_x, i_vec_y, i_vec_z;
    logic signed [31:0] i_axis_x, i_axis_y, i_axis_z;
    logic signed [31:0] i_turn_angle;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic               o_axis_was_zero;

    t_rotation_board board;
    bit              calm;
    int              cycle_count;

    axis_angle_vector_rotation_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("axis_angle_vector_rotation_core verification failed");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_stall <= !calm && ($urandom_range(99) < 18);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rot_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.x = o_out_x;
            got.y = o_out_y;
            got.z = o_out_z;
            got.zero = o_axis_was_zero;
            board.check_result(got);
        end
    end

    // drive one item and hold it until taken
    task automatic send_item(t_rot_req rq);
        while (!calm && $urandom_range(99) < 18) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_mode       <= rq.mode;
        i_vec_x      <= rq.vec[0];
        i_vec_y      <= rq.vec[1];
        i_vec_z      <= rq.vec[2];
        i_axis_x     <= rq.axis[0];
        i_axis_y     <= rq.axis[1];
        i_axis_z     <= rq.axis[2];
        i_turn_angle <= rq.angle;
        do @(posedge i_clk); while (o_stall);
        board.note_input(rq);
    endtask

    function automatic logic [31:0] pick_comp();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            4: return $urandom_range(0, 64) - 32;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(7))
            0: return {2'($urandom_range(3)), 30'd0} + $urandom_range(0, 8) - 4;
            1: return {3'($urandom_range(7)), 29'd0};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_rot_req random_req();
        t_rot_req rq;
        rq.mode = 2'($urandom_range(3));
        if ($urandom_range(3) == 0) rq.mode = MODE_AXIS;
        for (int i = 0; i < 3; i++) begin
            rq.vec[i] = pick_comp();
            rq.axis[i] = pick_comp();
        end
        // zero and single-component axes now and then
        case ($urandom_range(9))
            0: rq.axis = '{0, 0, 0};
            1: rq.axis[$urandom_range(2)] = 0;
            2: begin
                rq.axis = '{0, 0, 0};
                rq.axis[$urandom_range(2)] = pick_comp();
            end
            default: ;
        endcase
        rq.angle = pick_angle();
        return rq;
    endfunction

    function automatic t_rot_req make_req(logic [1:0] md, logic [31:0] v0, logic [31:0] v1,
                                          logic [31:0] v2, logic [31:0] a0, logic [31:0] a1,
                                          logic [31:0] a2, logic [31:0] ang);
        t_rot_req rq;
        rq.mode = md;
        rq.vec = '{v0, v1, v2};
        rq.axis = '{a0, a1, a2};
        rq.angle = ang;
        return rq;
    endfunction

    initial begin
        board = new();
        calm = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = MODE_X;
        {i_vec_x, i_vec_y, i_vec_z} = '0;
        {i_axis_x, i_axis_y, i_axis_z} = '0;
        i_turn_angle = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each mode, quadrant edges, extremes, zero axis
        send_item(make_req(MODE_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 0));
        send_item(make_req(MODE_Y, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                           0, 0, 0, 32'h4000_0000));
        send_item(make_req(MODE_Z, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                           0, 0, 0, 32'h8000_0000));
        send_item(make_req(MODE_X, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 0, 0, 32'hc000_0000));
        send_item(make_req(MODE_Y, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           0, 32'h8000_0000, 0, 32'h2000_0000));
        send_item(make_req(MODE_Z, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           0, 0, 32'hffff_ffff, 32'he000_0000));
        send_item(make_req(MODE_AXIS, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000,
                           0, 0, 0, 32'h1234_5678));
        send_item(make_req(MODE_AXIS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           0, 0, 0, 32'h8000_0000));
        send_item(make_req(MODE_AXIS, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h2aaa_aaab));
        send_item(make_req(MODE_AXIS, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h6000_0000));
        send_item(make_req(MODE_AXIS, 32'h0003_0000, 32'hfffd_0000, 32'h0001_0000,
                           1, 0, 0, 32'h4000_0000));
        send_item(make_req(MODE_AXIS, 32'h0003_0000, 32'hfffd_0000, 32'h0001_0000,
                           0, 32'hffff_ffff, 1, 32'h1fff_ffff));
        send_item(make_req(MODE_AXIS, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                           32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff));
        send_item(make_req(MODE_X, 32'hffff_ffff, 1, 32'hffff_ffff,
                           32'h5555_5555, 32'haaaa_aaaa, 1, 32'hffff_ffff));
        send_item(make_req(MODE_Z, 32'h0000_0001, 32'hffff_ffff, 0,
                           0, 0, 0, 32'h3fff_ffff));

        // random items, with a stretch of no idling in the middle
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 150 && n < 260);
            send_item(random_req());
        end
        calm = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (board.pending_vecs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.n_errors == 0)
            $display("axis_angle_vector_rotation_core verification clean");
        else
            $display("axis_angle_vector_rotation_core verification failed");
        $finish;
    end
endmodule
